### rtl/obfn_pkg.sv
package obfn_pkg;

  // component width and fixed-point scale (one sign bit, one integer bit)
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned FRAC_W     = VALUE_W - 2;
  localparam int unsigned PROD_W     = 2 * VALUE_W;

  // quotient of a product by |D| is at most 2^VALUE_W
  localparam int unsigned QUOT_W     = VALUE_W + 1;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIV_STAGES = (QUOT_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned QP_W       = DIV_STAGES * DIV_STEPS;
  localparam int unsigned CMP_W      = VALUE_W + 1 + QP_W;
  localparam int unsigned SAT_W      = QP_W + 2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [SAT_W-1:0]   wide_t;

  localparam wide_t ONE_WIDE = wide_t'(1) << FRAC_W;

  // input request: unit normal
  typedef struct packed {
    value_t dir_x;
    value_t dir_y;
    value_t dir_z;
  } dir_t;

  // result request: tangent and bitangent
  typedef struct packed {
    value_t tangent_x;
    value_t tangent_y;
    value_t tangent_z;
    value_t bitangent_x;
    value_t bitangent_y;
    value_t bitangent_z;
  } basis_t;

  // clamp a wide signed value to -1.0 .. 1.0
  function automatic value_t sat_value(wide_t v);
    value_t r;
    if (v > ONE_WIDE) begin
      r = value_t'(ONE_WIDE);
    end else if (v < -ONE_WIDE) begin
      r = value_t'(-ONE_WIDE);
    end else begin
      r = value_t'(v);
    end
    return r;
  endfunction

endpackage

### rtl/orthonormal_basis_from_normal.sv
// Completes an orthonormal basis from a unit normal (dir_x, dir_y, dir_z) given in signed
// fixed point with VALUE_W-2 fraction bits, using the branchless construction with
// s = +1 for z >= 0 (zero included) and -1 otherwise. The three quotients x*x/|D|,
// y*y/|D| and x*y/|D| (D = s + z) are rounded to nearest, ties away from zero, and every
// result component is clamped to -1.0 .. 1.0. The block is fully pipelined: it takes one
// request per clock while stall_o is low, and each request passes through the input,
// multiply and rounding-bias registers, the DIV_STAGES stages of the restoring divider,
// which retires two quotient bits per stage, and the output register. Each stage holds
// its request while the stage after it is full and stalled, so bubbles are squeezed out
// and stall_o rises only once every stage is occupied.
module orthonormal_basis_from_normal import obfn_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   stall_o,
  input  dir_t   dir_i,
  output logic   valid_o,
  input  logic   stall_i,
  output basis_t basis_o
);

  localparam int unsigned ST_PREP = 0;
  localparam int unsigned ST_MUL  = 1;
  localparam int unsigned ST_BIAS = 2;
  localparam int unsigned ST_DIV0 = 3;
  localparam int unsigned ST_OUT  = ST_DIV0 + DIV_STAGES;
  localparam int unsigned N_ST    = ST_OUT + 1;

  typedef struct packed {
    logic   neg;
    logic   xy_neg;
    value_t tz;
    value_t bz;
  } side_t;

  typedef struct packed {
    logic [VALUE_W-1:0] mx;
    logic [VALUE_W-1:0] my;
    logic [VALUE_W-1:0] dm;
    side_t              side;
  } prep_t;

  typedef struct packed {
    logic [PROD_W-1:0]  pxx;
    logic [PROD_W-1:0]  pyy;
    logic [PROD_W-1:0]  pxy;
    logic [VALUE_W-1:0] dm;
    side_t              side;
  } mul_t;

  typedef struct packed {
    logic [PROD_W-1:0] rem_xx;
    logic [PROD_W-1:0] rem_yy;
    logic [PROD_W-1:0] rem_xy;
    logic [QP_W-1:0]   q_xx;
    logic [QP_W-1:0]   q_yy;
    logic [QP_W-1:0]   q_xy;
    logic [VALUE_W:0]  d2;
    side_t             side;
  } div_t;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [PROD_W:0] div_step(logic [PROD_W-1:0] rem,
                                                logic [CMP_W-1:0] dsh);
    logic [PROD_W:0] r;
    if (CMP_W'(rem) >= dsh) begin
      r = {1'b1, rem - dsh[PROD_W-1:0]};
    end else begin
      r = {1'b0, rem};
    end
    return r;
  endfunction

  // stage occupancy and backpressure chain
  logic [N_ST-1:0] vld_q;
  logic [N_ST:0]   rdy;
  logic [N_ST-1:0] vin;
  logic [N_ST-1:0] ld;

  assign rdy[N_ST] = !stall_i;
  for (genvar k = 0; k < N_ST; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end
  assign vin     = {vld_q[N_ST-2:0], valid_i};
  assign ld      = vin & rdy[N_ST-1:0];
  assign stall_o = !rdy[0];
  assign valid_o = vld_q[N_ST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= (vld_q & ~rdy[N_ST-1:0]) | ld;
    end
  end

  // input stage: sign, |D|, magnitudes, the two direct components
  prep_t prep_d, prep_q;

  always_comb begin
    wide_t x_w, y_w, z_w, dm_w, mx_w, my_w;
    logic  neg;
    x_w  = wide_t'(dir_i.dir_x);
    y_w  = wide_t'(dir_i.dir_y);
    z_w  = wide_t'(dir_i.dir_z);
    neg  = dir_i.dir_z[VALUE_W-1];
    dm_w = neg ? (ONE_WIDE - z_w) : (ONE_WIDE + z_w);
    mx_w = dir_i.dir_x[VALUE_W-1] ? -x_w : x_w;
    my_w = dir_i.dir_y[VALUE_W-1] ? -y_w : y_w;
    prep_d.mx          = mx_w[VALUE_W-1:0];
    prep_d.my          = my_w[VALUE_W-1:0];
    prep_d.dm          = dm_w[VALUE_W-1:0];
    prep_d.side.neg    = neg;
    prep_d.side.xy_neg = dir_i.dir_x[VALUE_W-1] ^ dir_i.dir_y[VALUE_W-1];
    prep_d.side.tz     = sat_value(neg ? x_w : -x_w);
    prep_d.side.bz     = sat_value(-y_w);
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_PREP]) begin
      prep_q <= prep_d;
    end
  end

  // product stage
  mul_t mul_d, mul_q;

  always_comb begin
    mul_d.pxx  = PROD_W'(prep_q.mx) * PROD_W'(prep_q.mx);
    mul_d.pyy  = PROD_W'(prep_q.my) * PROD_W'(prep_q.my);
    mul_d.pxy  = PROD_W'(prep_q.mx) * PROD_W'(prep_q.my);
    mul_d.dm   = prep_q.dm;
    mul_d.side = prep_q.side;
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_MUL]) begin
      mul_q <= mul_d;
    end
  end

  // rounding bias: round(P/|D|) = floor((2P + |D|) / 2|D|)
  div_t bias_d, bias_q;

  always_comb begin
    bias_d.rem_xx = (mul_q.pxx << 1) + PROD_W'(mul_q.dm);
    bias_d.rem_yy = (mul_q.pyy << 1) + PROD_W'(mul_q.dm);
    bias_d.rem_xy = (mul_q.pxy << 1) + PROD_W'(mul_q.dm);
    bias_d.q_xx   = '0;
    bias_d.q_yy   = '0;
    bias_d.q_xy   = '0;
    bias_d.d2     = {mul_q.dm, 1'b0};
    bias_d.side   = mul_q.side;
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_BIAS]) begin
      bias_q <= bias_d;
    end
  end

  // divider stages, msb first, DIV_STEPS quotient bits each
  div_t div_in [DIV_STAGES];
  div_t div_d  [DIV_STAGES];
  div_t div_q  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    if (k == 0) begin : g_first
      assign div_in[k] = bias_q;
    end else begin : g_next
      assign div_in[k] = div_q[k-1];
    end

    always_comb begin
      logic [CMP_W-1:0] dsh;
      logic [PROD_W:0]  sx, sy, sxy;
      int               sh;
      div_d[k] = div_in[k];
      for (int j = 0; j < DIV_STEPS; j++) begin
        sh  = QP_W - 1 - (k * DIV_STEPS + j);
        dsh = CMP_W'(div_in[k].d2) << sh;
        sx  = div_step(div_d[k].rem_xx, dsh);
        sy  = div_step(div_d[k].rem_yy, dsh);
        sxy = div_step(div_d[k].rem_xy, dsh);
        div_d[k].rem_xx = sx[PROD_W-1:0];
        div_d[k].rem_yy = sy[PROD_W-1:0];
        div_d[k].rem_xy = sxy[PROD_W-1:0];
        div_d[k].q_xx   = div_d[k].q_xx | (QP_W'(sx[PROD_W]) << sh);
        div_d[k].q_yy   = div_d[k].q_yy | (QP_W'(sy[PROD_W]) << sh);
        div_d[k].q_xy   = div_d[k].q_xy | (QP_W'(sxy[PROD_W]) << sh);
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[ST_DIV0+k]) begin
        div_q[k] <= div_d[k];
      end
    end
  end

  // output stage: signs and clamping
  basis_t basis_d, basis_q;

  always_comb begin
    wide_t  qxx_w, qyy_w, qxy_w, ty_w;
    value_t ty, byv;
    logic   neg;
    neg   = div_q[DIV_STAGES-1].side.neg;
    qxx_w = wide_t'(div_q[DIV_STAGES-1].q_xx);
    qyy_w = wide_t'(div_q[DIV_STAGES-1].q_yy);
    qxy_w = wide_t'(div_q[DIV_STAGES-1].q_xy);
    ty_w  = div_q[DIV_STAGES-1].side.xy_neg ? qxy_w : -qxy_w;
    ty    = sat_value(ty_w);
    byv   = sat_value(ONE_WIDE - qyy_w);
    basis_d.tangent_x   = sat_value(ONE_WIDE - qxx_w);
    basis_d.tangent_y   = ty;
    basis_d.tangent_z   = div_q[DIV_STAGES-1].side.tz;
    basis_d.bitangent_x = neg ? -ty : ty;
    basis_d.bitangent_y = neg ? -byv : byv;
    basis_d.bitangent_z = div_q[DIV_STAGES-1].side.bz;
  end

  always_ff @(posedge clk_i) begin
    if (ld[ST_OUT]) begin
      basis_q <= basis_d;
    end
  end

  assign basis_o = basis_q;

  // checks
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (basis_o.tangent_x <= ONE_WIDE) && (basis_o.tangent_x >= -ONE_WIDE) &&
                (basis_o.bitangent_y <= ONE_WIDE) && (basis_o.bitangent_y >= -ONE_WIDE))
    else $error("basis component outside -1..1");

  a_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (basis_o.bitangent_x == basis_o.tangent_y) ||
                (basis_o.bitangent_x == -basis_o.tangent_y))
    else $error("bitangent x and tangent y differ in magnitude");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && stall_i) |-> stall_o)
    else $error("request taken while every stage is full and stalled");

  a_denom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_DIV0] |-> (div_q[0].d2[VALUE_W:FRAC_W+1] != '0))
    else $error("divisor below one");

endmodule
